// ===== rtl/mt19937_64_generator_core_assert.svh =====
// Assertion macros shared by the generator core files.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef MT19937_64_GENERATOR_CORE_ASSERT_SVH
`define MT19937_64_GENERATOR_CORE_ASSERT_SVH

// Check that a condition holds at every edge.
`define MT64_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MT64_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define MT64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mt64_pkg.sv =====
// ----------------------------------------------------------------------------
// mt64_pkg: shared definitions for the 64-bit Mersenne Twister core
// Sizes, twist and tempering constants, codes, and the bus structs that
// run between the sequencer and the iterative multiplier.
// ----------------------------------------------------------------------------
package mt64_pkg;

	// Store geometry
	localparam int STATE_WORDS  = 312;
	localparam int TWIST_OFFSET = 156;
	localparam int TWIST_TAP    = TWIST_OFFSET % STATE_WORDS;
	localparam int IDX_W        = $clog2(STATE_WORDS);

	// Seeding multiplier and twist matrix
	localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;
	localparam logic [63:0] TWIST_A   = 64'hB5026F5AA96619E9;

	// Tempering
	localparam int          TEMPER_U = 29;
	localparam logic [63:0] TEMPER_D = 64'h5555555555555555;
	localparam int          TEMPER_S = 17;
	localparam logic [63:0] TEMPER_B = 64'h71D67FFFEDA60000;
	localparam int          TEMPER_T = 37;
	localparam logic [63:0] TEMPER_C = 64'hFFF7EEE000000000;
	localparam int          TEMPER_L = 43;

	// Item kinds; the fourth code is accepted and ignored
	typedef enum logic [1:0] {
		KIND_RESEED  = 2'd0,
		KIND_RAW     = 2'd1,
		KIND_BOUNDED = 2'd2
	} kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED_PUSH,
		ST_SEED_MUL,
		ST_DRAW_MUL
	} state_t;

	// Multiplier request and response
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	// Twist one word from the head, its neighbor and the far tap
	function automatic logic [63:0] twist_word(input logic [63:0] head,
			input logic [63:0] next, input logic [63:0] tap);
		logic [63:0] x;
		x = {head[63:31], next[30:0]};
		return tap ^ (x >> 1) ^ (x[0] ? TWIST_A : 64'd0);
	endfunction

	// Temper a twisted word into the output value
	function automatic logic [63:0] temper(input logic [63:0] w);
		logic [63:0] y;
		y = w;
		y = y ^ ((y >> TEMPER_U) & TEMPER_D);
		y = y ^ ((y << TEMPER_S) & TEMPER_B);
		y = y ^ ((y << TEMPER_T) & TEMPER_C);
		y = y ^ (y >> TEMPER_L);
		return y;
	endfunction

	// Fold the top bits of the previous word before the seeding multiply
	function automatic logic [63:0] seed_mix(input logic [63:0] p);
		return p ^ (p >> 62);
	endfunction

endpackage

// ===== rtl/mt64_if.sv =====
// ----------------------------------------------------------------------------
// mt64_if: valid/ready channels of the generator core
// mt64_req_if carries input items, mt64_rsp_if carries result words.
// ----------------------------------------------------------------------------
interface mt64_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] seed_value;
	logic [63:0] bound;

	modport source (output valid, output kind, output seed_value, output bound,
		input ready);
	modport sink (input valid, input kind, input seed_value, input bound,
		output ready);
endinterface

interface mt64_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/mt64_cell.sv =====
// ----------------------------------------------------------------------------
// mt64_cell: one word of the rotating state line
// Holds a state word and takes its neighbor's word on each shift.
// ----------------------------------------------------------------------------
module mt64_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  logic [63:0] d,
	output logic [63:0] q
);

	logic [63:0] word_q;

	// Clear to zero on reset, take the neighbor on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ===== rtl/mt64_mul.sv =====
// ----------------------------------------------------------------------------
// mt64_mul: iterative 64 x 64 multiplier
// Forms the 128-bit product from four 32 x 32 partial products, one per
// cycle, each registered before it is added into the accumulator.
// ----------------------------------------------------------------------------
`include "mt19937_64_generator_core_assert.svh"

module mt64_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mt64_pkg::mul_req_t req,
	output mt64_pkg::mul_rsp_t rsp
);

	localparam logic [2:0] STEP_END  = 3'd4;
	localparam logic [2:0] STEP_LAST = 3'd3;

	logic         busy_q;
	logic [2:0]   step_q;
	logic         pp_vld_q;
	logic         pp_last_q;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [127:0] acc_q;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  pp_d;
	logic         pp_go;

	// Pick operand halves: step bit 0 selects the high half of a, bit 1 of b
	assign mul_a = step_q[0] ? a_q[63:32] : a_q[31:0];
	assign mul_b = step_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp_d  = mul_a * mul_b;
	assign pp_go = busy_q && !req.start && (step_q != STEP_END);

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			pp_vld_q  <= 1'b0;
			pp_last_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= pp_vld_q && pp_last_q;
			if (req.start) begin
				busy_q   <= 1'b1;
				step_q   <= '0;
				pp_vld_q <= 1'b0;
			end else if (busy_q) begin
				pp_vld_q <= pp_go;
				if (pp_go) begin
					step_q    <= step_q + 3'd1;
					pp_last_q <= (step_q == STEP_LAST);
				end
				if (pp_vld_q && pp_last_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (pp_vld_q) begin
			acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
		end
		if (pp_go) begin
			pp_q <= pp_d;
			sh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	`MT64_ASSERT_IMP(a_mul_no_restart, req.start, !busy_q, "multiplier restarted while busy")
	`MT64_ASSERT_IMP(a_mul_pp_in_op, pp_vld_q, busy_q, "partial product outside an operation")
	`MT64_ASSERT_IMP(a_mul_done_idle, done_q, !busy_q && !pp_vld_q, "done while still working")

endmodule

// ===== rtl/mt19937_64_generator_core.sv =====
// ----------------------------------------------------------------------------
// mt19937_64_generator_core: 64-bit Mersenne Twister with raw and bounded draws
// The 312 state words sit in a rotating line of cells; the head word is
// twisted on demand. A raw draw tempers the twisted head word into the
// result stage, and from there it moves to the output register before it can
// transfer out. The result stage must empty into the output register before
// the next item is taken. A bounded draw waits on the shared 32 x 32
// multiplier, which builds the 128-bit product in four passes; the product
// is then captured in the result stage and moved to the output register.
// A reseed pushes the words into the line one at a time, each word after
// the first waiting on that same multiplier, and no item is accepted until
// the reseed ends.
// ----------------------------------------------------------------------------
`include "mt19937_64_generator_core_assert.svh"

module mt19937_64_generator_core (
	input  logic      clk,
	input  logic      arst_n,
	mt64_req_if.sink   req,
	mt64_rsp_if.source rsp
);

	localparam logic [mt64_pkg::IDX_W-1:0] IDX_LAST =
		mt64_pkg::IDX_W'(mt64_pkg::STATE_WORDS - 1);

	mt64_pkg::state_t   state_q, state_d;
	mt64_pkg::mul_req_t mul_req;
	mt64_pkg::mul_rsp_t mul_rsp;

	logic [63:0] cell_q [mt64_pkg::STATE_WORDS];
	logic [63:0] tail_word;
	logic [63:0] twisted;
	logic [63:0] draw_val;
	logic        shift_en;
	logic        req_ready;
	logic        accept;
	logic        draw_go;
	logic        bounded_go;
	logic        seed_go;
	logic        push;

	logic [63:0]                word_q;
	logic [mt64_pkg::IDX_W-1:0] idx_q;
	logic [63:0]                res_q;
	logic                       res_valid_q;
	logic [63:0]                out_value_q;
	logic                       out_valid_q;
	logic                       res_move;

	// State line: each cell takes its right neighbor, the last takes the tail word
	for (genvar k = 0; k < mt64_pkg::STATE_WORDS; k++) begin : g_cell
		if (k == mt64_pkg::STATE_WORDS - 1) begin : g_tail
			mt64_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift_en),
				.d      (tail_word),
				.q      (cell_q[k])
			);
		end else begin : g_body
			mt64_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift_en),
				.d      (cell_q[k+1]),
				.q      (cell_q[k])
			);
		end
	end

	// Twist the head word and temper it
	assign twisted  = mt64_pkg::twist_word(cell_q[0], cell_q[1],
		cell_q[mt64_pkg::TWIST_TAP]);
	assign draw_val = mt64_pkg::temper(twisted);

	mt64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mt64_pkg::ST_IDLE: begin
				if (seed_go) begin
					state_d = mt64_pkg::ST_SEED_PUSH;
				end else if (bounded_go) begin
					state_d = mt64_pkg::ST_DRAW_MUL;
				end
			end
			mt64_pkg::ST_SEED_PUSH: begin
				state_d = (idx_q == IDX_LAST) ? mt64_pkg::ST_IDLE : mt64_pkg::ST_SEED_MUL;
			end
			mt64_pkg::ST_SEED_MUL: begin
				if (mul_rsp.done) begin
					state_d = mt64_pkg::ST_SEED_PUSH;
				end
			end
			mt64_pkg::ST_DRAW_MUL: begin
				if (mul_rsp.done) begin
					state_d = mt64_pkg::ST_IDLE;
				end
			end
			default: state_d = mt64_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_ready  = (state_q == mt64_pkg::ST_IDLE) && !res_valid_q;
		accept     = req.valid && req_ready;
		draw_go    = 1'b0;
		bounded_go = 1'b0;
		seed_go    = 1'b0;
		case (req.kind)
			mt64_pkg::KIND_RESEED:  seed_go = accept;
			mt64_pkg::KIND_RAW:     draw_go = accept;
			mt64_pkg::KIND_BOUNDED: begin
				draw_go    = accept;
				bounded_go = accept;
			end
			default: ;
		endcase
		push          = (state_q == mt64_pkg::ST_SEED_PUSH);
		shift_en      = draw_go || push;
		tail_word     = push ? word_q : twisted;
		mul_req.start = bounded_go || (push && (idx_q != IDX_LAST));
		mul_req.a     = push ? mt64_pkg::seed_mix(word_q) : draw_val;
		mul_req.b     = push ? mt64_pkg::SEED_MULT : req.bound;
	end

	assign req.ready = req_ready;
	assign res_move  = res_valid_q && (!out_valid_q || rsp.ready);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mt64_pkg::ST_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seed_go) begin
				idx_q <= '0;
			end else if (state_q == mt64_pkg::ST_SEED_MUL && mul_rsp.done) begin
				idx_q <= idx_q + mt64_pkg::IDX_W'(1);
			end
			// Drain the result stage into the output register
			if (res_move) begin
				res_valid_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((draw_go && !bounded_go) ||
				(state_q == mt64_pkg::ST_DRAW_MUL && mul_rsp.done)) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	// Seed word and result payload
	always_ff @(posedge clk) begin
		if (seed_go) begin
			word_q <= req.seed_value;
		end else if (state_q == mt64_pkg::ST_SEED_MUL && mul_rsp.done) begin
			word_q <= mul_rsp.prod[63:0] + 64'(idx_q) + 64'd1;
		end
		if (draw_go && !bounded_go) begin
			res_q <= draw_val;
		end else if (state_q == mt64_pkg::ST_DRAW_MUL && mul_rsp.done) begin
			res_q <= mul_rsp.prod[127:64];
		end
		if (res_move) begin
			out_value_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;

	`MT64_ASSERT_IMP(a_done_in_mul_state, mul_rsp.done,
		state_q == mt64_pkg::ST_SEED_MUL || state_q == mt64_pkg::ST_DRAW_MUL,
		"multiplier result outside a multiply state")
	`MT64_ASSERT_IMP(a_start_when_free, mul_req.start, !mul_rsp.busy,
		"multiplier started while busy")
	`MT64_ASSERT_NEXT(a_raw_result, draw_go && !bounded_go, res_valid_q,
		"raw draw left no pending result")
	`MT64_ASSERT_IMP(a_mul_wait_busy, state_q == mt64_pkg::ST_SEED_MUL && !mul_rsp.done,
		mul_rsp.busy, "waiting on an idle multiplier")

endmodule

// ===== dv/mt19937_64_generator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_64_generator_core_test: self-checking bench for the MT19937-64 core
// Sends reseed, raw draw, bounded draw and unused items through the request
// channel. A local copy of the generator state predicts each result word, and
// every word on the response channel is compared with the oldest prediction.
// Both channels stall at random, apart from one long steady stretch.
// ----------------------------------------------------------------------------
module mt19937_64_generator_core_test;

	// Generator constants for the local prediction
	localparam logic [63:0] MULT_SEED  = 64'd6364136223846793005;
	localparam logic [63:0] MATRIX_A   = 64'hB5026F5AA96619E9;
	localparam logic [63:0] MASK_D     = 64'h5555555555555555;
	localparam logic [63:0] MASK_B     = 64'h71D67FFFEDA60000;
	localparam logic [63:0] MASK_C     = 64'hFFF7EEE000000000;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES   = 64'hFFFFFFFFFFFFFFFF;
	localparam int          IDLE_PCT   = 21;
	localparam int          DRAIN_MAX  = 5000;
	localparam int          TAIL_CYCLES = 16;

	logic clk;
	logic arst_n;

	mt64_req_if req_ch ();
	mt64_rsp_if rsp_ch ();

	mt19937_64_generator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of the generator state
	logic [63:0] mt_words [mt64_pkg::STATE_WORDS];
	int          mt_pos;

	logic [63:0] expected_values [$];
	int          error_count;
	bit          steady_flow;

	// Clock
	always #1 clk = ~clk;

	// Load the state words from a seed; the next draw twists first
	function automatic void reseed_words(input logic [63:0] seed);
		logic [63:0] prev;
		mt_words[0] = seed;
		for (int i = 1; i < mt64_pkg::STATE_WORDS; i++) begin
			prev = mt_words[i - 1];
			mt_words[i] = MULT_SEED * (prev ^ (prev >> 62)) + 64'(i);
		end
		mt_pos = mt64_pkg::STATE_WORDS;
	endfunction

	// Regenerate the whole store in place
	function automatic void twist_words();
		logic [63:0] joined;
		logic [63:0] mixed;
		for (int i = 0; i < mt64_pkg::STATE_WORDS; i++) begin
			joined = {mt_words[i][63:31],
				mt_words[(i + 1) % mt64_pkg::STATE_WORDS][30:0]};
			mixed = joined >> 1;
			if (joined[0])
				mixed = mixed ^ MATRIX_A;
			mt_words[i] = mt_words[(i + mt64_pkg::TWIST_OFFSET) % mt64_pkg::STATE_WORDS]
				^ mixed;
		end
		mt_pos = 0;
	endfunction

	// Take the next tempered word, twisting when the store is used up
	function automatic logic [63:0] next_raw_word();
		logic [63:0] y;
		if (mt_pos >= mt64_pkg::STATE_WORDS)
			twist_words();
		y = mt_words[mt_pos];
		y = y ^ ((y >> 29) & MASK_D);
		y = y ^ ((y << 17) & MASK_B);
		y = y ^ ((y << 37) & MASK_C);
		y = y ^ (y >> 43);
		mt_pos++;
		return y;
	endfunction

	// High half of the 128-bit product of a raw word and the bound
	function automatic logic [63:0] scale_to_bound(input logic [63:0] raw,
			input logic [63:0] limit);
		logic [127:0] prod;
		prod = {64'd0, raw} * {64'd0, limit};
		return prod[127:64];
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Pick a bound with the edges weighted in
	function automatic logic [63:0] rand_bound();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return 64'($urandom_range(1, 1000));
			3: return 64'd1 << $urandom_range(63);
			default: return rand_word();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// Send one item, predict its result at the transfer
	task automatic send_item(input logic [1:0] kind, input logic [63:0] seed,
			input logic [63:0] limit);
		// idle the request channel at random
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.seed_value <= seed;
		req_ch.bound      <= limit;
		do
			@(posedge clk);
		while (!req_ch.ready);
		case (kind)
			mt64_pkg::KIND_RESEED:  reseed_words(seed);
			mt64_pkg::KIND_RAW:     expected_values.push_back(next_raw_word());
			mt64_pkg::KIND_BOUNDED:
				expected_values.push_back(scale_to_bound(next_raw_word(), limit));
			default: ;
		endcase
	endtask

	// Response sink: stall at random unless the flow is steady
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		logic [63:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_values.size() == 0) begin
				report_mismatch("result with nothing expected", rsp_ch.value, 64'd0);
			end else begin
				want = expected_values.pop_front();
				if (rsp_ch.value !== want)
					report_mismatch("value", rsp_ch.value, want);
			end
		end
	end

	// Draws before any reseed see an all-zero store; the unused kind is dropped
	task automatic test_unseeded_draws();
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), ALL_ONES);
		send_item(KIND_UNUSED, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_RAW, ALL_ONES, ALL_ONES);
	endtask

	// Seed and bound extremes, with the unused kind between draws
	task automatic test_seed_extremes();
		send_item(mt64_pkg::KIND_RESEED, 64'd0, rand_word());
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), 64'd0);
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), ALL_ONES);
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), 64'd1);
		send_item(mt64_pkg::KIND_RESEED, ALL_ONES, rand_word());
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), ALL_ONES);
		send_item(mt64_pkg::KIND_BOUNDED, rand_word(), 64'h8000000000000000);
		send_item(KIND_UNUSED, ALL_ONES, ALL_ONES);
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_RESEED, 64'd5489, rand_word());
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
	endtask

	// Run past a full store with no stalls, so the twist repeats back to back
	task automatic test_twist_wrap();
		steady_flow = 1'b1;
		send_item(mt64_pkg::KIND_RESEED, rand_word(), rand_word());
		for (int n = 0; n < 2 * mt64_pkg::STATE_WORDS / 2 + 20; n++) begin
			if ($urandom_range(3) == 0)
				send_item(mt64_pkg::KIND_BOUNDED, rand_word(), rand_bound());
			else
				send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
		end
		steady_flow = 1'b0;
	endtask

	// Mostly draws with random bounds, occasional reseeds and unused items
	task automatic test_random_mix();
		int pick;
		for (int n = 0; n < 740; n++) begin
			pick = $urandom_range(99);
			if (pick < 3)
				send_item(mt64_pkg::KIND_RESEED, rand_word(), rand_word());
			else if (pick < 5)
				send_item(KIND_UNUSED, rand_word(), rand_word());
			else if (pick < 55)
				send_item(mt64_pkg::KIND_RAW, rand_word(), rand_word());
			else
				send_item(mt64_pkg::KIND_BOUNDED, rand_word(), rand_bound());
		end
	endtask

	// Stimulus and end of run
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		error_count = 0;
		steady_flow = 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= mt64_pkg::KIND_RAW;
		req_ch.seed_value <= 64'd0;
		req_ch.bound      <= 64'd0;
		for (int i = 0; i < mt64_pkg::STATE_WORDS; i++)
			mt_words[i] = 64'd0;
		mt_pos = mt64_pkg::STATE_WORDS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_draws();
		test_seed_extremes();
		test_twist_wrap();
		test_random_mix();

		// drain outstanding results, then let the pipeline settle
		req_ch.valid <= 1'b0;
		for (int n = 0; n < DRAIN_MAX && expected_values.size() != 0; n++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_values.size() != 0)
			report_mismatch("results never arrived",
				64'(expected_values.size()), 64'd0);

		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== mt19937_64_generator_core.f =====
+incdir+rtl
rtl/mt64_pkg.sv
rtl/mt64_if.sv
rtl/mt64_cell.sv
rtl/mt64_mul.sv
rtl/mt19937_64_generator_core.sv
dv/mt19937_64_generator_core_test.sv
